@@ hw/rtl/ptd_pkg.sv @@
// ----------------------------------------------------------------------------
// ptd_pkg - shared definitions for the periodic task dispatcher
// Slot count, request codes, stream packing widths and the control/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ptd_pkg;

	localparam int NumTasks = 8;
	localparam int TaskW    = (NumTasks > 1) ? $clog2(NumTasks) : 1;
	localparam int MaskW    = 8;     // run_mask and periodic_mask width
	localparam int TimeW    = 32;
	localparam int ReqW     = 3;
	localparam int IdxW     = 3;
	localparam int SlotExtW = 6;     // holds any slot number up to 63

	// request payload packing in tdata, lowest bits first; req_type rides in tuser
	localparam int InBits   = IdxW + TimeW + TimeW;
	localparam int InDataW  = ((InBits + 7) / 8) * 8;
	localparam int OutDataW = ((MaskW + 7) / 8) * 8;

	localparam logic [ReqW-1:0] REQ_DISPATCH   = 3'd0;
	localparam logic [ReqW-1:0] REQ_ACTIVATE   = 3'd1;
	localparam logic [ReqW-1:0] REQ_DEACTIVATE = 3'd2;
	localparam logic [ReqW-1:0] REQ_SET_PERIOD = 3'd3;
	localparam logic [ReqW-1:0] REQ_REFRESH    = 3'd4;

	typedef struct packed {
		logic load;        // capture the accepted request
		logic edit;        // apply a slot edit request
		logic sweep_step;  // evaluate one slot of a dispatch pass
		logic out_load;    // move the finished mask to the output register
	} ptd_cmd_t;

	typedef struct packed {
		logic is_dispatch;
		logic sweep_last;
	} ptd_status_t;

endpackage

@@ hw/rtl/ptd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptd_ctrl - dispatcher sequencer
// Accepts one request, runs the slot sweep or the edit, then hands the
// result to the output register.
// ----------------------------------------------------------------------------
module ptd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  ptd_pkg::ptd_status_t status,
	output ptd_pkg::ptd_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.load       = in_valid && in_ready;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (status.is_dispatch) begin
					cmd.sweep_step = 1'b1;
					if (status.sweep_last) state_d = ST_DONE;
				end else begin
					cmd.edit = 1'b1;
					state_d  = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

@@ hw/rtl/ptd_datapath.sv @@
// ----------------------------------------------------------------------------
// ptd_datapath - task slot state and dispatch evaluation
// Holds per-slot active flag, start time and period, sweeps one slot per
// step and builds the run mask.
// ----------------------------------------------------------------------------
module ptd_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ptd_pkg::MaskW-1:0]     cfg_wdata,
	input  logic [ptd_pkg::ReqW-1:0]      req_type,
	input  logic [ptd_pkg::IdxW-1:0]      task_index,
	input  logic [ptd_pkg::TimeW-1:0]     new_period,
	input  logic [ptd_pkg::TimeW-1:0]     timestamp,
	input  ptd_pkg::ptd_cmd_t             cmd,
	output ptd_pkg::ptd_status_t          status,
	output logic [ptd_pkg::MaskW-1:0]     run_mask
);

	logic [ptd_pkg::MaskW-1:0] periodic_mask_q;
	logic                      active_q [ptd_pkg::NumTasks];
	logic [ptd_pkg::TimeW-1:0] start_q  [ptd_pkg::NumTasks];
	logic [ptd_pkg::TimeW-1:0] period_q [ptd_pkg::NumTasks];

	logic [ptd_pkg::ReqW-1:0]  req_q;
	logic [ptd_pkg::IdxW-1:0]  idx_q;
	logic [ptd_pkg::TimeW-1:0] per_q;
	logic [ptd_pkg::TimeW-1:0] now_q;
	logic [ptd_pkg::TaskW-1:0] cnt_q;
	logic [ptd_pkg::MaskW-1:0] run_q;
	logic [ptd_pkg::MaskW-1:0] out_q;

	logic [ptd_pkg::SlotExtW-1:0] cnt_ext;
	logic [ptd_pkg::SlotExtW-1:0] idx_ext;
	logic [ptd_pkg::TaskW-1:0]    slot;
	logic                         cnt_periodic;
	logic                         idx_periodic;
	logic                         idx_ok;
	logic [ptd_pkg::TimeW-1:0]    elapsed;
	logic                         due;

	assign cnt_ext = ptd_pkg::SlotExtW'(cnt_q);
	assign idx_ext = ptd_pkg::SlotExtW'(idx_q);
	assign slot    = idx_ext[ptd_pkg::TaskW-1:0];
	assign idx_ok  = idx_ext < ptd_pkg::SlotExtW'(ptd_pkg::NumTasks);

	// slots from eight up have no periodic bit and no run bit
	assign cnt_periodic = (cnt_ext < ptd_pkg::SlotExtW'(ptd_pkg::MaskW))
	                      && periodic_mask_q[cnt_ext[2:0]];
	assign idx_periodic = periodic_mask_q[idx_q];

	assign elapsed = now_q - start_q[cnt_q];
	assign due     = active_q[cnt_q] && (!cnt_periodic || (elapsed >= period_q[cnt_q]))
	                 && (cnt_ext < ptd_pkg::SlotExtW'(ptd_pkg::MaskW));

	assign status.is_dispatch = (req_q == ptd_pkg::REQ_DISPATCH);
	assign status.sweep_last  = (cnt_ext == ptd_pkg::SlotExtW'(ptd_pkg::NumTasks - 1));
	assign run_mask           = out_q;

	// request capture and mask accumulation
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			idx_q <= task_index;
			per_q <= new_period;
			now_q <= timestamp;
			run_q <= '0;
		end else if (cmd.sweep_step && due) begin
			run_q <= run_q | (ptd_pkg::MaskW'(1) << cnt_ext[2:0]);
		end
		if (cmd.out_load) out_q <= run_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			periodic_mask_q <= '0;
			cnt_q           <= '0;
			for (int i = 0; i < ptd_pkg::NumTasks; i++) begin
				active_q[i] <= 1'b0;
				start_q[i]  <= '0;
				period_q[i] <= '0;
			end
		end else begin
			if (cfg_we) periodic_mask_q <= cfg_wdata;
			if (cmd.load) cnt_q <= '0;
			else if (cmd.sweep_step) cnt_q <= cnt_q + ptd_pkg::TaskW'(1);
			if (cmd.sweep_step && due && cnt_periodic) start_q[cnt_q] <= now_q;
			if (cmd.edit && idx_ok) begin
				case (req_q)
					ptd_pkg::REQ_ACTIVATE: begin
						active_q[slot] <= 1'b1;
						if (idx_periodic) start_q[slot] <= now_q;
					end
					ptd_pkg::REQ_DEACTIVATE: active_q[slot] <= 1'b0;
					ptd_pkg::REQ_SET_PERIOD: period_q[slot] <= per_q;
					ptd_pkg::REQ_REFRESH:    start_q[slot]  <= now_q;
					default: ;
				endcase
			end
		end
	end

endmodule

@@ hw/rtl/periodic_task_dispatcher_top.sv @@
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_top - cooperative periodic task dispatcher
// Streaming request in, run mask out, one mask per request.
// ----------------------------------------------------------------------------
// Each request is taken when the block is idle and yields exactly one run
// mask. A dispatch pass sweeps the task slots one per cycle through a single
// elapsed-time subtract and compare; the request is accepted, each slot is
// evaluated in turn and the result is then handed over. Activate, deactivate,
// set period and refresh apply one slot edit and return a zero mask. A result
// waiting at the output does not block the next request from being taken;
// the block holds in its final step only until the output register is free.
// The periodic_mask register marks each slot periodic (1) or every-pass (0)
// and must be written while no request is in flight.
module periodic_task_dispatcher_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration: periodic_mask
	input  logic                           cfg_we,
	input  logic [ptd_pkg::MaskW-1:0]      cfg_wdata,
	// request stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// fields from bit 0: req_type[2:0]
	input  logic [ptd_pkg::ReqW-1:0]       s_tuser,
	// fields from bit 0: task_index[2:0], new_period[34:3],
	// timestamp[66:35], zero pad [71:67]
	input  logic [ptd_pkg::InDataW-1:0]    s_tdata,
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// fields from bit 0: run_mask[7:0]
	output logic [ptd_pkg::OutDataW-1:0]   m_tdata
);

	ptd_pkg::ptd_cmd_t         cmd;
	ptd_pkg::ptd_status_t      status;
	logic [ptd_pkg::MaskW-1:0] run_mask;

	// unpack the request payload
	logic [ptd_pkg::ReqW-1:0]  req_type;
	logic [ptd_pkg::IdxW-1:0]  task_index;
	logic [ptd_pkg::TimeW-1:0] new_period;
	logic [ptd_pkg::TimeW-1:0] timestamp;

	assign req_type   = s_tuser;
	assign task_index = s_tdata[2:0];
	assign new_period = s_tdata[34:3];
	assign timestamp  = s_tdata[66:35];

	assign m_tdata = ptd_pkg::OutDataW'(run_mask);

	// sequencer: accept, sweep or edit, hand over
	ptd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	// slot state, elapsed-time check and run mask build
	ptd_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_type   (req_type),
		.task_index (task_index),
		.new_period (new_period),
		.timestamp  (timestamp),
		.cmd        (cmd),
		.status     (status),
		.run_mask   (run_mask)
	);

	// a taken request closes the input until its result is handed over
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in flight");

	// never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(m_tvalid && !m_tready))
		else $error("pending run mask overwritten");

	// slot edits never run for a dispatch pass, nor alongside a sweep step
	a_edit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.edit |-> !status.is_dispatch && !cmd.sweep_step)
		else $error("slot edit issued during a dispatch pass");

endmodule
